/* sv/script_token_scanner_assert.svh */
// assertion helpers for the token scanner
`ifndef SCRIPT_TOKEN_SCANNER_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_ASSERT_SVH

// condition must never hold outside reset
`define STS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define STS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/sts_pkg.sv */
package sts_pkg;

  localparam int unsigned SrcBytes = 65536;
  localparam int unsigned KwChars  = 6;
  localparam int unsigned KwNum    = 10;
  localparam int unsigned PosW     = $clog2(SrcBytes + 2);
  localparam int unsigned KwCntW   = $clog2(KwChars + 2);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [4:0] {
    TokLParen = 5'd0,  TokRParen = 5'd1,  TokLBrace = 5'd2,  TokRBrace = 5'd3,
    TokComma  = 5'd4,  TokSemi   = 5'd5,  TokMinus  = 5'd6,  TokPlus   = 5'd7,
    TokSlash  = 5'd8,  TokStar   = 5'd9,  TokBang   = 5'd10, TokBangEq = 5'd11,
    TokEq     = 5'd12, TokEqEq   = 5'd13, TokGt     = 5'd14, TokGe     = 5'd15,
    TokLt     = 5'd16, TokLe     = 5'd17, TokIdent  = 5'd18, TokString = 5'd19,
    TokNumber = 5'd20, TokFn     = 5'd21, TokLet    = 5'd22, TokIf     = 5'd23,
    TokElse   = 5'd24, TokReturn = 5'd25, TokWhile  = 5'd26, TokPrint  = 5'd27,
    TokTrue   = 5'd28, TokFalse  = 5'd29, TokNil    = 5'd30, TokEof    = 5'd31
  } tok_e;

  typedef enum logic [1:0] {
    ErrNone       = 2'd0,
    ErrUnexpected = 2'd1,
    ErrUntermStr  = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ModeIdle, ModeIdent, ModeNumInt, ModeNumDot, ModeNumFrac, ModeString,
    ModeBang, ModeEqual, ModeGreater, ModeLess, ModeError
  } mode_e;

  typedef struct packed {
    tok_e        token_type;
    err_e        error_code;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        source_done;
    logic        run_last;
  } res_t;

  typedef logic [KwChars-1:0][7:0] wbuf_t;

  // keyword text right-aligned, first character in the highest byte used
  localparam logic [8*KwChars-1:0] KwText [KwNum] = '{
    "fn", "let", "if", "else", "return", "while", "print", "true", "false", "nil"
  };
  localparam int KwLen [KwNum] = '{2, 3, 2, 4, 6, 5, 5, 4, 5, 3};
  localparam tok_e KwType [KwNum] = '{
    TokFn, TokLet, TokIf, TokElse, TokReturn, TokWhile, TokPrint, TokTrue, TokFalse,
    TokNil
  };

  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChEquals = 8'h3D;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [15:0] sat16(logic [PosW-1:0] v);
    return (v > PosW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] len_add(logic [15:0] l, logic [1:0] n);
    logic [16:0] s;
    s = {1'b0, l} + {15'd0, n};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic res_t mk_res(tok_e t, err_e e, logic [PosW-1:0] s, logic [15:0] l,
                                  logic d);
    res_t r;
    r.token_type   = t;
    r.error_code   = e;
    r.token_start  = sat16(s);
    r.token_length = l;
    r.source_done  = d;
    r.run_last     = 1'b0;
    return r;
  endfunction

  // parallel compare of the word against every keyword
  function automatic tok_e kw_lookup(wbuf_t wb, logic [KwCntW-1:0] cnt);
    tok_e t;
    logic hit;
    t = TokIdent;
    for (int k = 0; k < KwNum; k++) begin
      hit = (cnt == KwCntW'(KwLen[k]));
      for (int i = 0; i < KwChars; i++) begin
        if (i < KwLen[k]) begin
          hit = hit && (wb[i] == KwText[k][8*(KwLen[k]-1-i) +: 8]);
        end
      end
      if (hit) begin
        t = KwType[k];
      end
    end
    return t;
  endfunction

  function automatic tok_e cmp_one(mode_e m);
    tok_e t;
    unique case (m)
      ModeBang:    t = TokBang;
      ModeEqual:   t = TokEq;
      ModeGreater: t = TokGt;
      default:     t = TokLt;
    endcase
    return t;
  endfunction

  function automatic tok_e cmp_two(mode_e m);
    tok_e t;
    unique case (m)
      ModeBang:    t = TokBangEq;
      ModeEqual:   t = TokEqEq;
      ModeGreater: t = TokGe;
      default:     t = TokLe;
    endcase
    return t;
  endfunction

endpackage

/* sv/sts_in_if.sv */
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

/* sv/sts_out_if.sv */
interface sts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_type;
  logic [1:0]  error_code;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        source_done;
  logic        run_last;

  modport source (output valid, output token_type, output error_code, output token_start,
                  output token_length, output source_done, output run_last, input ready);
  modport sink   (input valid, input token_type, input error_code, input token_start,
                  input token_length, input source_done, input run_last, output ready);
endinterface

/* sv/script_token_scanner.sv */
// a byte passes the input register, then the result queue, before its first token shows
// throughput: one byte per cycle while the result queue has two free entries; a byte
//   that yields two tokens writes both into the queue together, ahead of the single result port
// results drain through a four-entry queue that keeps taking bytes while tokens wait
// reset: scanner idle at offset 0, word buffer cleared, input stage and queue empty
`include "script_token_scanner_assert.svh"

module script_token_scanner (
  input  logic      clk_i,
  input  logic      rst_ni,
  sts_in_if.sink    in_i,
  sts_out_if.source out_o
);
  import sts_pkg::*;

  // input register stage
  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_eos_q;
  logic       s1_go;

  // scanner state
  mode_e             mode_q, mode_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   start_q, start_d;
  logic [15:0]       len_q, len_d;
  wbuf_t             wbuf_q, wbuf_d;
  logic [KwCntW-1:0] wcnt_q, wcnt_d;

  // result queue
  res_t               fifo_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0] cnt_q;
  logic               pop;

  // results of one byte: the token it closes, then the token or error it makes
  res_t       res_a, res_b, slot0, slot1;
  logic       a_v, b_v;
  logic [1:0] n_res;

  // a byte may enter the compute stage when two queue entries are free
  assign s1_go     = s1_valid_q && (cnt_q <= OutCntW'(OutDepth - 2));
  assign in_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q  <= in_i.ch;
      s1_eos_q <= in_i.end_of_source;
    end
  end

  // next scanner state and the results of the byte in the input register
  always_comb begin
    logic       reproc;
    logic       failed;
    logic [7:0] b;
    b       = s1_ch_q;
    reproc  = 1'b0;
    failed  = 1'b0;
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    wbuf_d  = wbuf_q;
    wcnt_d  = wcnt_q;
    a_v     = 1'b0;
    b_v     = 1'b0;
    res_a   = mk_res(TokLParen, ErrNone, pos_q, 16'd0, 1'b0);
    res_b   = res_a;

    if (s1_eos_q) begin
      // end marker: flush the pending token, then EOF if no error; silent in error mode
      if (mode_q != ModeError) begin
        unique case (mode_q)
          ModeIdent: begin
            a_v   = 1'b1;
            res_a = mk_res(kw_lookup(wbuf_q, wcnt_q), ErrNone, start_q, len_q, 1'b0);
          end
          ModeNumInt, ModeNumFrac: begin
            a_v   = 1'b1;
            res_a = mk_res(TokNumber, ErrNone, start_q, len_q, 1'b0);
          end
          ModeNumDot: begin
            a_v    = 1'b1;
            res_a  = mk_res(TokNumber, ErrNone, start_q, len_q, 1'b0);
            b_v    = 1'b1;
            res_b  = mk_res(TokLParen, ErrUnexpected, pos_q - PosW'(1), 16'd1, 1'b1);
            failed = 1'b1;
          end
          ModeString: begin
            a_v    = 1'b1;
            res_a  = mk_res(TokLParen, ErrUntermStr, start_q, len_q, 1'b1);
            failed = 1'b1;
          end
          ModeBang, ModeEqual, ModeGreater, ModeLess: begin
            a_v   = 1'b1;
            res_a = mk_res(cmp_one(mode_q), ErrNone, start_q, 16'd1, 1'b0);
          end
          default: ;
        endcase
        if (!failed) begin
          b_v   = 1'b1;
          res_b = mk_res(TokEof, ErrNone, pos_q, 16'd0, 1'b1);
        end
      end
      // rearm for the next source
      mode_d  = ModeIdle;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      wbuf_d  = '0;
      wcnt_d  = '0;
    end else begin
      unique case (mode_q)
        ModeError: ;
        ModeString: begin
          if (b == ChQuote) begin
            a_v    = 1'b1;
            res_a  = mk_res(TokString, ErrNone, start_q, len_q, 1'b0);
            mode_d = ModeIdle;
          end else begin
            len_d = len_add(len_q, 2'd1);
          end
        end
        ModeIdent: begin
          if (is_alpha(b) || is_digit(b) || b == ChUnder) begin
            for (int i = 0; i < KwChars; i++) begin
              if (wcnt_q == KwCntW'(i)) begin
                wbuf_d[i] = b;
              end
            end
            if (wcnt_q <= KwCntW'(KwChars)) begin
              wcnt_d = wcnt_q + KwCntW'(1);
            end
            len_d = len_add(len_q, 2'd1);
          end else begin
            a_v    = 1'b1;
            res_a  = mk_res(kw_lookup(wbuf_q, wcnt_q), ErrNone, start_q, len_q, 1'b0);
            mode_d = ModeIdle;
            reproc = 1'b1;
          end
        end
        ModeNumInt: begin
          if (is_digit(b)) begin
            len_d = len_add(len_q, 2'd1);
          end else if (b == ChDot) begin
            mode_d = ModeNumDot;
          end else begin
            a_v    = 1'b1;
            res_a  = mk_res(TokNumber, ErrNone, start_q, len_q, 1'b0);
            mode_d = ModeIdle;
            reproc = 1'b1;
          end
        end
        ModeNumDot: begin
          // a fraction needs a digit right after the dot
          if (is_digit(b)) begin
            len_d  = len_add(len_q, 2'd2);
            mode_d = ModeNumFrac;
          end else begin
            a_v    = 1'b1;
            res_a  = mk_res(TokNumber, ErrNone, start_q, len_q, 1'b0);
            b_v    = 1'b1;
            res_b  = mk_res(TokLParen, ErrUnexpected, pos_q - PosW'(1), 16'd1, 1'b1);
            mode_d = ModeError;
          end
        end
        ModeNumFrac: begin
          if (is_digit(b)) begin
            len_d = len_add(len_q, 2'd1);
          end else begin
            a_v    = 1'b1;
            res_a  = mk_res(TokNumber, ErrNone, start_q, len_q, 1'b0);
            mode_d = ModeIdle;
            reproc = 1'b1;
          end
        end
        ModeBang, ModeEqual, ModeGreater, ModeLess: begin
          // one byte of lookahead decides between the one and two byte forms
          a_v    = 1'b1;
          mode_d = ModeIdle;
          if (b == ChEquals) begin
            res_a = mk_res(cmp_two(mode_q), ErrNone, start_q, 16'd2, 1'b0);
          end else begin
            res_a  = mk_res(cmp_one(mode_q), ErrNone, start_q, 16'd1, 1'b0);
            reproc = 1'b1;
          end
        end
        default: begin
          mode_d = ModeIdle;
          reproc = 1'b1;
        end
      endcase

      // the byte as the start of a new lexeme
      if (reproc && !is_space(b)) begin
        if (is_alpha(b)) begin
          mode_d    = ModeIdent;
          start_d   = pos_q;
          len_d     = 16'd1;
          wbuf_d    = '0;
          wbuf_d[0] = b;
          wcnt_d    = KwCntW'(1);
        end else if (is_digit(b)) begin
          mode_d  = ModeNumInt;
          start_d = pos_q;
          len_d   = 16'd1;
        end else begin
          unique case (b)
            8'h28: begin b_v = 1'b1; res_b = mk_res(TokLParen, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h29: begin b_v = 1'b1; res_b = mk_res(TokRParen, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h7B: begin b_v = 1'b1; res_b = mk_res(TokLBrace, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h7D: begin b_v = 1'b1; res_b = mk_res(TokRBrace, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h2C: begin b_v = 1'b1; res_b = mk_res(TokComma, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h3B: begin b_v = 1'b1; res_b = mk_res(TokSemi, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h2D: begin b_v = 1'b1; res_b = mk_res(TokMinus, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h2B: begin b_v = 1'b1; res_b = mk_res(TokPlus, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h2F: begin b_v = 1'b1; res_b = mk_res(TokSlash, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h2A: begin b_v = 1'b1; res_b = mk_res(TokStar, ErrNone, pos_q, 16'd1, 1'b0); end
            8'h21: begin mode_d = ModeBang;    start_d = pos_q; len_d = 16'd1; end
            8'h3D: begin mode_d = ModeEqual;   start_d = pos_q; len_d = 16'd1; end
            8'h3E: begin mode_d = ModeGreater; start_d = pos_q; len_d = 16'd1; end
            8'h3C: begin mode_d = ModeLess;    start_d = pos_q; len_d = 16'd1; end
            ChQuote: begin
              // string offsets skip the opening quote
              mode_d  = ModeString;
              start_d = pos_q + PosW'(1);
              len_d   = 16'd0;
            end
            default: begin
              b_v    = 1'b1;
              res_b  = mk_res(TokLParen, ErrUnexpected, pos_q, 16'd1, 1'b1);
              mode_d = ModeError;
            end
          endcase
        end
      end

      // offset counter stops at the source size
      if (pos_q < PosW'(SrcBytes)) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // pack the results into slots in order and mark the last one
  always_comb begin
    slot0 = a_v ? res_a : res_b;
    slot1 = res_b;
    n_res = {1'b0, a_v} + {1'b0, b_v};
    slot0.run_last = (n_res == 2'd1);
    slot1.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      wbuf_q  <= '0;
      wcnt_q  <= '0;
    end else if (s1_go) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      wbuf_q  <= wbuf_d;
      wcnt_q  <= wcnt_d;
    end
  end

  // result queue: up to two writes, one read per cycle
  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (s1_go && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (s1_go && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + OutPtrW'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s1_go) begin
        wr_ptr_q <= wr_ptr_q + OutPtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      cnt_q <= cnt_q + (s1_go ? OutCntW'(n_res) : OutCntW'(0)) - OutCntW'(pop);
    end
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.token_type   = fifo_q[rd_ptr_q].token_type;
  assign out_o.error_code   = fifo_q[rd_ptr_q].error_code;
  assign out_o.token_start  = fifo_q[rd_ptr_q].token_start;
  assign out_o.token_length = fifo_q[rd_ptr_q].token_length;
  assign out_o.source_done  = fifo_q[rd_ptr_q].source_done;
  assign out_o.run_last     = fifo_q[rd_ptr_q].run_last;

  // checks
  `STS_ASSERT_NEVER(a_queue_bound, cnt_q > OutCntW'(OutDepth), "result queue overflow")
  `STS_ASSERT_NEVER(a_pos_bound, pos_q > PosW'(SrcBytes), "offset counter past source size")
  `STS_ASSERT_IMPLIES(a_quiet_after_error, s1_go && !s1_eos_q && mode_q == ModeError,
                      n_res == 2'd0, "token emitted after an error")
  `STS_ASSERT_IMPLIES(a_error_is_last, s1_go && n_res == 2'd2 && slot0.source_done,
                      1'b0, "error result followed by another result")

endmodule
